/* sv/spslw_pkg.sv */
package spslw_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned MS_W      = 12;
   localparam int unsigned TICK_W    = 8;
   localparam int unsigned TIMER_W   = 16;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 12;
   localparam int unsigned REPLY_W   = 3;
   localparam int unsigned CHOICE_W  = 2;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

   typedef enum logic [3:0] {
      PH_SYNCED = 4'b0001,
      PH_START  = 4'b0010,
      PH_STEP1  = 4'b0100,
      PH_OUT    = 4'b1000
   } phase_type;

   typedef enum logic [0:0] {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   typedef enum logic [REPLY_W-1:0] {
      RPL_SYNC_START = 3'd0,
      RPL_SYNC_STEP1 = 3'd1,
      RPL_SYNC_OK    = 3'd2,
      RPL_ACK        = 3'd3,
      RPL_NACK       = 3'd4
   } reply_type;

   typedef enum logic [CHOICE_W-1:0] {
      RPT_LIVE      = 2'd0,
      RPT_IDLE      = 2'd1,
      RPT_IDLE_HOME = 2'd2
   } choice_type;

   typedef enum logic [STATUS_W-1:0] {
      LNK_NOT_SYNCED   = 2'd0,
      LNK_LIVE         = 2'd1,
      LNK_PAUSED_EMPTY = 2'd2,
      LNK_PAUSED_HOME  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYNC_START = 3'd0,
      REG_SYNC_STEP1 = 3'd1,
      REG_SYNC_STEP2 = 3'd2,
      REG_PAUSE_MS   = 3'd3,
      REG_HOME_MS    = 3'd4,
      REG_HOLD_MS    = 3'd5,
      REG_TICK_MS    = 3'd6
   } csr_index_type;

   localparam logic [CODE_W-1:0]  RST_SYNC_START = 8'd255;
   localparam logic [CODE_W-1:0]  RST_SYNC_STEP1 = 8'd51;
   localparam logic [CODE_W-1:0]  RST_SYNC_STEP2 = 8'd204;
   localparam logic [MS_W-1:0]    RST_PAUSE_MS   = 12'd120;
   localparam logic [MS_W-1:0]    RST_HOME_MS    = 12'd800;
   localparam logic [MS_W-1:0]    RST_HOLD_MS    = 12'd200;
   localparam logic [TICK_W-1:0]  RST_TICK_MS    = 8'd8;

   // CRC-8, MSB first
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] d;
      d = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (d[BYTE_W-1]) begin
            d = {d[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            d = {d[BYTE_W-2:0], 1'b0};
         end
      end
      return d;
   endfunction

endpackage

/* sv/spslw_if.sv */
interface spslw_req_if;
   logic                            valid;
   logic                            ready;
   spslw_pkg::command_type          command;
   logic [spslw_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface spslw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             reply_valid;
   logic [spslw_pkg::REPLY_W-1:0]    reply_code;
   logic                             packet_accepted;
   logic [spslw_pkg::DATA_W-1:0]     packet_data;
   logic                             slot_loaded;
   logic [spslw_pkg::CHOICE_W-1:0]   report_choice;
   logic [spslw_pkg::STATUS_W-1:0]   link_status;
   logic                             synced;

   modport source (output valid, output reply_valid, output reply_code,
                   output packet_accepted, output packet_data, output slot_loaded,
                   output report_choice, output link_status, output synced,
                   input ready);
   modport sink   (input valid, input reply_valid, input reply_code,
                   input packet_accepted, input packet_data, input slot_loaded,
                   input report_choice, input link_status, input synced,
                   output ready);
endinterface

interface spslw_csr_if;
   logic                               valid;
   logic                               ready;
   logic [spslw_pkg::CSR_IDX_W-1:0]    index;
   logic [spslw_pkg::CSR_DAT_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/serial_packet_sync_link_watchdog_top.sv */
// channel    dir  handshake     payload
// req_chan   in   valid/ready   command, rx_byte
// rsp_chan   out  valid/ready   reply_valid, reply_code, packet_accepted, packet_data,
//                               slot_loaded, report_choice, link_status, synced
// csr_chan   in   valid/ready   index, data (ready always high)
//
// One request per cycle unless the response stalls; input, then result register.
// All per-request work is one combinational pass over the sync/frame/timer state.
// Synchronous active-high reset returns configuration, link state and valid flags to defaults, link out of sync.
// A stalled response holds the result register; the input register still drains into it
// in the same cycle the response is taken, so ready only drops when both are full.
module serial_packet_sync_link_watchdog_top #(
   parameter int unsigned PAYLOAD_BYTES = 8
) (
   input  logic         clock,
   input  logic         reset,
   spslw_req_if.sink    req_chan,
   spslw_rsp_if.source  rsp_chan,
   spslw_csr_if.sink    csr_chan
);

   localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int unsigned B_W   = spslw_pkg::BYTE_W;

   // configuration
   logic [spslw_pkg::CODE_W-1:0] start_code_ff, step1_code_ff, step2_code_ff;
   logic [spslw_pkg::MS_W-1:0]   pause_ms_ff, home_ms_ff, hold_ms_ff;
   logic [spslw_pkg::TICK_W-1:0] tick_ms_ff;

   // input register
   logic                   in_valid_ff;
   spslw_pkg::command_type in_cmd_ff;
   logic [B_W-1:0]         in_byte_ff;

   // link state
   spslw_pkg::phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [B_W-1:0]                 crc_ff, crc_in;
   logic [B_W-1:0]                 frame_ff [PAYLOAD_BYTES];
   logic                           frame_we;
   logic [spslw_pkg::DATA_W-1:0]   held_ff, held_in, packed_frame;
   logic                           present_ff, present_in;
   logic [spslw_pkg::TIMER_W-1:0]  elapsed_ff, elapsed_in, elapsed_add;
   logic [spslw_pkg::TIMER_W:0]    elapsed_sum;
   logic [spslw_pkg::MS_W:0]       home_end;

   // result register
   logic                           out_valid_ff;
   logic                           rv_ff, rv_in;
   spslw_pkg::reply_type           rc_ff, rc_in;
   logic                           acc_ff, acc_in;
   spslw_pkg::choice_type          choice_ff, choice_in;
   spslw_pkg::status_type          status_ff, status_in;

   logic advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= spslw_pkg::RST_SYNC_START;
         step1_code_ff <= spslw_pkg::RST_SYNC_STEP1;
         step2_code_ff <= spslw_pkg::RST_SYNC_STEP2;
         pause_ms_ff   <= spslw_pkg::RST_PAUSE_MS;
         home_ms_ff    <= spslw_pkg::RST_HOME_MS;
         hold_ms_ff    <= spslw_pkg::RST_HOLD_MS;
         tick_ms_ff    <= spslw_pkg::RST_TICK_MS;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            spslw_pkg::REG_SYNC_START: start_code_ff <= csr_chan.data[spslw_pkg::CODE_W-1:0];
            spslw_pkg::REG_SYNC_STEP1: step1_code_ff <= csr_chan.data[spslw_pkg::CODE_W-1:0];
            spslw_pkg::REG_SYNC_STEP2: step2_code_ff <= csr_chan.data[spslw_pkg::CODE_W-1:0];
            spslw_pkg::REG_PAUSE_MS:   pause_ms_ff   <= csr_chan.data;
            spslw_pkg::REG_HOME_MS:    home_ms_ff    <= csr_chan.data;
            spslw_pkg::REG_HOLD_MS:    hold_ms_ff    <= csr_chan.data;
            spslw_pkg::REG_TICK_MS:    tick_ms_ff    <= csr_chan.data[spslw_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.command;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_comb begin
      packed_frame = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         packed_frame[spslw_pkg::DATA_W-1-B_W*i -: B_W] = frame_ff[i];
      end
   end

   assign elapsed_sum = {1'b0, elapsed_ff} + (spslw_pkg::TIMER_W+1)'(tick_ms_ff);
   assign elapsed_add = elapsed_sum[spslw_pkg::TIMER_W] ? '1 :
                        elapsed_sum[spslw_pkg::TIMER_W-1:0];
   assign home_end    = {1'b0, home_ms_ff} + {1'b0, hold_ms_ff};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      held_in    = held_ff;
      present_in = present_ff;
      elapsed_in = elapsed_ff;
      frame_we   = 1'b0;
      rv_in      = 1'b0;
      rc_in      = spslw_pkg::RPL_SYNC_START;
      acc_in     = 1'b0;
      choice_in  = spslw_pkg::RPT_LIVE;
      status_in  = spslw_pkg::LNK_NOT_SYNCED;
      if (in_cmd_ff == spslw_pkg::CMD_BYTE) begin
         unique case (phase_ff)
            spslw_pkg::PH_SYNCED: begin
               if (count_ff < CNT_W'(PAYLOAD_BYTES)) begin
                  frame_we = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  crc_in   = spslw_pkg::crc8_step(crc_ff, in_byte_ff);
               end else begin
                  rv_in = 1'b1;
                  if (crc_ff != in_byte_ff) begin
                     if (in_byte_ff == start_code_ff) begin
                        phase_in = spslw_pkg::PH_START;
                        rc_in    = spslw_pkg::RPL_SYNC_START;
                     end else begin
                        rc_in = spslw_pkg::RPL_NACK;
                     end
                  end else begin
                     rc_in      = spslw_pkg::RPL_ACK;
                     acc_in     = 1'b1;
                     held_in    = packed_frame;
                     present_in = 1'b1;
                     elapsed_in = '0;
                  end
                  count_in = '0;
                  crc_in   = '0;
               end
            end
            spslw_pkg::PH_START: begin
               if (in_byte_ff == step1_code_ff) begin
                  phase_in = spslw_pkg::PH_STEP1;
                  rv_in    = 1'b1;
                  rc_in    = spslw_pkg::RPL_SYNC_STEP1;
               end else begin
                  phase_in = spslw_pkg::PH_OUT;
               end
            end
            spslw_pkg::PH_STEP1: begin
               if (in_byte_ff == step2_code_ff) begin
                  phase_in = spslw_pkg::PH_SYNCED;
                  rv_in    = 1'b1;
                  rc_in    = spslw_pkg::RPL_SYNC_OK;
               end else begin
                  phase_in = spslw_pkg::PH_OUT;
               end
            end
            spslw_pkg::PH_OUT: ;
            default: ;
         endcase
         // a failing byte, or any byte while out of sync, may open a new handshake
         if (phase_in == spslw_pkg::PH_OUT && in_byte_ff == start_code_ff) begin
            phase_in = spslw_pkg::PH_START;
            rv_in    = 1'b1;
            rc_in    = spslw_pkg::RPL_SYNC_START;
         end
      end else begin
         if (phase_ff == spslw_pkg::PH_SYNCED) begin
            if (elapsed_ff >= spslw_pkg::TIMER_W'(pause_ms_ff)) begin
               if (elapsed_ff >= spslw_pkg::TIMER_W'(home_ms_ff) &&
                   elapsed_ff < spslw_pkg::TIMER_W'(home_end)) begin
                  choice_in = spslw_pkg::RPT_IDLE_HOME;
                  status_in = spslw_pkg::LNK_PAUSED_HOME;
               end else begin
                  choice_in = spslw_pkg::RPT_IDLE;
                  status_in = spslw_pkg::LNK_PAUSED_EMPTY;
               end
               if (elapsed_ff < spslw_pkg::TIMER_W'(home_end)) begin
                  elapsed_in = elapsed_add;
               end
            end else begin
               choice_in  = spslw_pkg::RPT_LIVE;
               status_in  = spslw_pkg::LNK_LIVE;
               elapsed_in = elapsed_add;
            end
         end else begin
            choice_in = spslw_pkg::RPT_IDLE;
            status_in = spslw_pkg::LNK_NOT_SYNCED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= spslw_pkg::PH_OUT;
         count_ff   <= '0;
         crc_ff     <= '0;
         held_ff    <= '0;
         present_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         held_ff    <= held_in;
         present_ff <= present_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && frame_we) begin
         frame_ff[count_ff[IDX_W-1:0]] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         rv_ff     <= rv_in;
         rc_ff     <= rc_in;
         acc_ff    <= acc_in;
         choice_ff <= choice_in;
         status_ff <= status_in;
      end
   end

   // held payload, slot flag and sync flag are the state after the latest request
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.reply_valid     = rv_ff;
   assign rsp_chan.reply_code      = rc_ff;
   assign rsp_chan.packet_accepted = acc_ff;
   assign rsp_chan.packet_data     = held_ff;
   assign rsp_chan.slot_loaded     = present_ff;
   assign rsp_chan.report_choice   = choice_ff;
   assign rsp_chan.link_status     = status_ff;
   assign rsp_chan.synced          = (phase_ff == spslw_pkg::PH_SYNCED);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PAYLOAD_BYTES))
      else $error("frame byte count beyond payload length");

   a_unsynced_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff != spslw_pkg::PH_SYNCED |-> count_ff == '0 && crc_ff == '0)
      else $error("frame state left over outside sync");

   a_ack_loads: assert property (@(posedge clock) disable iff (reset)
      advance && acc_in |=> present_ff && elapsed_ff == '0 &&
                            phase_ff == spslw_pkg::PH_SYNCED)
      else $error("accepted packet did not load the slot");

   a_tick_no_reply: assert property (@(posedge clock) disable iff (reset)
      advance && in_cmd_ff == spslw_pkg::CMD_TICK |=> !rv_ff && !acc_ff)
      else $error("reply raised on a report tick");

   a_status_sync: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff != spslw_pkg::LNK_NOT_SYNCED |-> rsp_chan.synced)
      else $error("link status reported while out of sync");

endmodule
